// ===== src/dtrh_pkg.sv =====
// shared types and constants for the device table with signal strength history
`default_nettype none

package dtrh_pkg;

    localparam int unsigned ADDR_W     = 48;
    localparam int unsigned STRENGTH_W = 8;
    localparam int unsigned INDEX_W    = 5;
    localparam int unsigned SLOT_W     = 4;

    // -100 dBm, written into every slot of a freshly created entry
    localparam logic [STRENGTH_W-1:0] FILL_STRENGTH = 8'h9C;

    typedef struct packed {
        logic [ADDR_W-1:0]            device_address;
        logic signed [STRENGTH_W-1:0] signal_strength;
    } t_sighting;

    typedef struct packed {
        logic [INDEX_W-1:0] entry_index;
        logic               was_new;
        logic               table_full;
        logic [SLOT_W-1:0]  slot_written;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_BASE,
        ST_SLOT,
        ST_FILL,
        ST_WRITE,
        ST_RESULT
    } t_state;

endpackage

`default_nettype wire

// ===== src/dtrh_ram.sv =====
// generic simple dual-port ram, one write port and one registered read port
`default_nettype none

module dtrh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== src/device_table_rssi_history_top.sv =====
// device sighting table with a per-device ring of signal strength values
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one sighting: a 48-bit
// device address and a signed strength. Output channel (o_out_valid / i_out_ready /
// o_out_data) gives one result per sighting: entry index, new-entry flag, table-full
// flag and the history slot written.
// Known addresses are scanned in insertion order through the address ram, one entry
// per cycle. A new address has each history slot of its entry filled in turn, as the
// history ram has one write port. A sighting that finds the table full is dropped. One
// sighting is worked on at a time and o_in_ready is high only while the sequencer is
// idle.
// Results sit in an output register, so the next sighting is taken while a result
// waits; if the receiver still stalls when the next result is ready, the sequencer
// holds in its final state until the output register frees.
// Synchronous reset empties the table (entry count to zero) and drops any pending
// result; the ram contents are not cleared and need no clearing pass.
`default_nettype none

module device_table_rssi_history_top #(
    parameter int MAX_DEVICES   = 32,
    parameter int HISTORY_DEPTH = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire dtrh_pkg::t_sighting i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output dtrh_pkg::t_result      o_out_data
);

    import dtrh_pkg::*;

    localparam int IW  = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam int CW  = $clog2(MAX_DEVICES + 1);
    localparam int PW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HD  = MAX_DEVICES * HISTORY_DEPTH;
    localparam int HAW = (HD > 1) ? $clog2(HD) : 1;

    t_state r_state, n_state;

    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_scan, n_scan;
    logic                  r_cmp_vld, n_cmp_vld;
    logic [IW-1:0]         r_cmp_idx, n_cmp_idx;
    logic [IW-1:0]         r_idx, n_idx;
    logic                  r_new, n_new;
    logic                  r_full, n_full;
    logic [PW-1:0]         r_slot, n_slot;
    logic [PW-1:0]         r_fill, n_fill;
    logic [HAW-1:0]        r_base, n_base;
    logic [ADDR_W-1:0]     r_addr, n_addr;
    logic [STRENGTH_W-1:0] r_strength, n_strength;
    logic                  r_out_vld, n_out_vld;
    t_result               r_out, n_out;

    // ram ports
    logic                  addr_we;
    logic [IW-1:0]         addr_waddr;
    logic [ADDR_W-1:0]     addr_rdata;
    logic                  ptr_we;
    logic [PW-1:0]         ptr_wdata;
    logic [PW-1:0]         ptr_rdata;
    logic                  hist_we;
    logic [HAW-1:0]        hist_waddr;
    logic [STRENGTH_W-1:0] hist_wdata;

    logic                  in_xfer;
    logic                  match;
    logic                  more;
    logic                  is_full;
    logic                  out_free;
    logic [PW:0]           slot_inc;
    logic [31:0]           idx_wide;
    logic [31:0]           slot_wide;
    logic [31:0]           base_prod;

    dtrh_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_DEVICES)) u_addr_ram (
        .i_clk   (i_clk),
        .i_we    (addr_we),
        .i_waddr (addr_waddr),
        .i_wdata (r_addr),
        .i_raddr (r_scan[IW-1:0]),
        .o_rdata (addr_rdata)
    );

    dtrh_ram #(.WIDTH(PW), .DEPTH(MAX_DEVICES)) u_ptr_ram (
        .i_clk   (i_clk),
        .i_we    (ptr_we),
        .i_waddr (r_idx),
        .i_wdata (ptr_wdata),
        .i_raddr (r_idx),
        .o_rdata (ptr_rdata)
    );

    dtrh_ram #(.WIDTH(STRENGTH_W), .DEPTH(HD)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_raddr (hist_waddr),
        .o_rdata ()
    );

    assign in_xfer   = i_in_valid && o_in_ready;
    assign match     = r_cmp_vld && (addr_rdata == r_addr);
    assign more      = r_scan < r_count;
    assign is_full   = r_count == CW'(MAX_DEVICES);
    assign out_free  = !r_out_vld || i_out_ready;
    assign slot_inc  = {1'b0, r_slot} + (PW+1)'(1);
    assign idx_wide  = 32'(r_idx);
    assign slot_wide = 32'(r_slot);
    assign base_prod = idx_wide * 32'(HISTORY_DEPTH);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_SEARCH;
            end
            ST_SEARCH: begin
                if (match) begin
                    n_state = ST_BASE;
                end else if (more) begin
                    n_state = ST_SEARCH;
                end else if (is_full) begin
                    n_state = ST_RESULT;
                end else begin
                    n_state = ST_BASE;
                end
            end
            ST_BASE: n_state = r_new ? ST_FILL : ST_SLOT;
            ST_SLOT: n_state = ST_WRITE;
            ST_FILL: begin
                if (r_fill == PW'(HISTORY_DEPTH - 1)) n_state = ST_WRITE;
            end
            ST_WRITE: n_state = ST_RESULT;
            ST_RESULT: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and ram controls
    always_comb begin
        n_count    = r_count;
        n_scan     = r_scan;
        n_cmp_vld  = r_cmp_vld;
        n_cmp_idx  = r_cmp_idx;
        n_idx      = r_idx;
        n_new      = r_new;
        n_full     = r_full;
        n_slot     = r_slot;
        n_fill     = r_fill;
        n_base     = r_base;
        n_addr     = r_addr;
        n_strength = r_strength;
        n_out_vld  = r_out_vld && !i_out_ready;
        n_out      = r_out;
        o_in_ready = 1'b0;
        addr_we    = 1'b0;
        addr_waddr = r_count[IW-1:0];
        ptr_we     = 1'b0;
        ptr_wdata  = (slot_inc >= (PW+1)'(HISTORY_DEPTH)) ? '0 : slot_inc[PW-1:0];
        hist_we    = 1'b0;
        hist_waddr = HAW'(r_base + HAW'(r_fill));
        hist_wdata = FILL_STRENGTH;

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (in_xfer) begin
                    n_addr     = i_in_data.device_address;
                    n_strength = i_in_data.signal_strength;
                    n_scan     = '0;
                    n_cmp_vld  = 1'b0;
                    n_new      = 1'b0;
                    n_full     = 1'b0;
                end
            end
            ST_SEARCH: begin
                // one address read per cycle, compared the cycle after
                n_cmp_vld = 1'b0;
                if (match) begin
                    n_idx = r_cmp_idx;
                end else if (more) begin
                    n_scan    = r_scan + CW'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_scan[IW-1:0];
                end else if (is_full) begin
                    n_full = 1'b1;
                    n_idx  = '0;
                    n_slot = '0;
                end else begin
                    n_idx   = r_count[IW-1:0];
                    n_new   = 1'b1;
                    n_slot  = '0;
                    addr_we = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            ST_BASE: begin
                n_base = HAW'(base_prod);
                n_fill = '0;
            end
            ST_SLOT: begin
                n_slot = ({1'b0, ptr_rdata} >= (PW+1)'(HISTORY_DEPTH)) ? '0 : ptr_rdata;
            end
            ST_FILL: begin
                hist_we = 1'b1;
                n_fill  = r_fill + PW'(1);
            end
            ST_WRITE: begin
                hist_we    = 1'b1;
                hist_waddr = HAW'(r_base + HAW'(r_slot));
                hist_wdata = r_strength;
                ptr_we     = 1'b1;
            end
            ST_RESULT: begin
                if (out_free) begin
                    n_out_vld          = 1'b1;
                    n_out.entry_index  = idx_wide[INDEX_W-1:0];
                    n_out.was_new      = r_new;
                    n_out.table_full   = r_full;
                    n_out.slot_written = slot_wide[SLOT_W-1:0];
                end
            end
            default: begin
                n_out_vld = r_out_vld && !i_out_ready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cmp_vld <= n_cmp_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan     <= n_scan;
        r_cmp_idx  <= n_cmp_idx;
        r_idx      <= n_idx;
        r_new      <= n_new;
        r_full     <= n_full;
        r_slot     <= n_slot;
        r_fill     <= n_fill;
        r_base     <= n_base;
        r_addr     <= n_addr;
        r_strength <= n_strength;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // entry count never passes the table size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_DEVICES))
        else $error("entry count beyond table size");

    // the count only ever grows by one, and only when the scan misses
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_count != $past(r_count)) |->
            (r_count == $past(r_count) + CW'(1)) && ($past(r_state) == ST_SEARCH))
        else $error("entry count changed outside a new-entry insertion");

    // a dropped sighting reports no entry and no slot
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.table_full |->
            !o_out_data.was_new && (o_out_data.entry_index == '0) &&
            (o_out_data.slot_written == '0))
        else $error("table-full result carries entry fields");

endmodule

`default_nettype wire

// ===== dv/device_table_rssi_history_top_tb.sv =====
// testbench for the device sighting table: directed and random sightings against a predictor
`timescale 1ns / 100ps

module device_table_rssi_history_top_tb;

    import dtrh_pkg::*;

    localparam int          MAX_DEVICES   = 32;
    localparam int          HISTORY_DEPTH = 16;
    localparam int          POOL_SIZE     = 32;
    localparam int          SETTLE_CYCLES = 80;
    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int          REPORT_LIMIT  = 10;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       in_valid   = 1'b0;
    t_sighting  in_data    = '0;
    logic       out_ready  = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_result    o_out_data;

    // own copy of the table
    logic [ADDR_W-1:0]     known_addr   [MAX_DEVICES];
    logic [SLOT_W-1:0]     next_slot    [MAX_DEVICES];
    logic [STRENGTH_W-1:0] ring_history [MAX_DEVICES][HISTORY_DEPTH];
    int                    known_count = 0;

    t_result           table_outcomes [$];
    logic [ADDR_W-1:0] address_pool   [POOL_SIZE];
    int                mismatch_count = 0;
    int unsigned       cycle_count    = 0;
    int                send_idle_pct  = 0;
    int                recv_idle_pct  = 0;

    device_table_rssi_history_top #(
        .MAX_DEVICES   (MAX_DEVICES),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // insertion-order search; append if unknown and not full, then record strength in ring
    function automatic t_result lookup_and_record(input t_sighting s);
        t_result r;
        int      idx;
        bit      found;
        bit      created;
        logic [SLOT_W-1:0] slot;
        r       = '0;
        idx     = 0;
        found   = 1'b0;
        created = 1'b0;
        for (int i = 0; i < known_count; i++) begin
            if (!found && known_addr[i] == s.device_address) begin
                idx   = i;
                found = 1'b1;
            end
        end
        if (!found) begin
            if (known_count >= MAX_DEVICES) begin
                r.table_full = 1'b1;
                return r;
            end
            idx = known_count;
            known_count++;
            known_addr[idx] = s.device_address;
            next_slot[idx]  = '0;
            for (int k = 0; k < HISTORY_DEPTH; k++)
                ring_history[idx][k] = FILL_STRENGTH;
            created = 1'b1;
        end
        slot = next_slot[idx];
        ring_history[idx][slot] = s.signal_strength;
        next_slot[idx] = (slot == HISTORY_DEPTH - 1) ? '0 : slot + 1'b1;
        r.entry_index  = idx[INDEX_W-1:0];
        r.was_new      = created;
        r.table_full   = 1'b0;
        r.slot_written = slot;
        return r;
    endfunction

    task automatic send_sighting(input logic [ADDR_W-1:0] addr,
                                 input logic [STRENGTH_W-1:0] strength);
        t_sighting s;
        s.device_address  = addr;
        s.signal_strength = strength;
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(64, 1)) @(posedge i_clk);
        end
        in_data  <= s;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        table_outcomes.push_back(lookup_and_record(s));
    endtask

    task automatic pause_until_drained;
        in_valid <= 1'b0;
        do @(posedge i_clk); while (table_outcomes.size() != 0);
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
    endtask

    task automatic test_extremes;
        send_sighting(address_pool[0], 8'h80);
        send_sighting(address_pool[1], 8'h7F);
        send_sighting(address_pool[2], 8'h00);
        send_sighting(address_pool[3], 8'hFF);
        send_sighting(address_pool[4], 8'h9C);
        send_sighting(address_pool[5], 8'h01);
        send_sighting(address_pool[1], 8'h80);
        send_sighting(address_pool[0], 8'h7F);
    endtask

    // sixteen revisits of one entry carry its pointer round past the last slot
    task automatic test_ring_wrap;
        for (int i = 0; i < HISTORY_DEPTH; i++)
            send_sighting(address_pool[2], 8'(i * 17 - 128));
    endtask

    task automatic test_random_sightings(input int count, input int fresh_pct);
        logic [ADDR_W-1:0] addr;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < fresh_pct)
                addr = ADDR_W'({$urandom(), $urandom()});
            else
                addr = address_pool[$urandom_range(POOL_SIZE - 1)];
            send_sighting(addr, 8'($urandom_range(255)));
        end
    endtask

    // fill from the pool, then unknown addresses, near misses among them, and a known one
    task automatic test_table_full;
        for (int i = 0; i < POOL_SIZE; i++)
            send_sighting(address_pool[i], 8'($urandom_range(255)));
        send_sighting(address_pool[0] ^ 48'h8000_0000_0000, 8'h80);
        send_sighting(address_pool[1] ^ 48'h1, 8'h7F);
        send_sighting(ADDR_W'({$urandom(), $urandom()}), 8'($urandom_range(255)));
        send_sighting(address_pool[0], 8'hFF);
    endtask

    task automatic note_mismatch(input t_result exp, input t_result act);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("mismatch: expected idx %0d new %0b full %0b slot %0d",
                     exp.entry_index, exp.was_new, exp.table_full, exp.slot_written);
            $display("          got idx %0d new %0b full %0b slot %0d",
                     act.entry_index, act.was_new, act.table_full, act.slot_written);
        end
    endtask

    // result side: check each transfer, then pick the next ready level
    always @(posedge i_clk) begin
        t_result exp;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (table_outcomes.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("unexpected result: idx %0d new %0b full %0b slot %0d",
                                 o_out_data.entry_index, o_out_data.was_new,
                                 o_out_data.table_full, o_out_data.slot_written);
                end else begin
                    exp = table_outcomes.pop_front();
                    if (o_out_data.entry_index !== exp.entry_index
                        || o_out_data.was_new !== exp.was_new
                        || o_out_data.table_full !== exp.table_full
                        || o_out_data.slot_written !== exp.slot_written)
                        note_mismatch(exp, o_out_data);
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        bit unique_addr;
        address_pool[0] = '0;
        address_pool[1] = '1;
        address_pool[2] = 48'h5555_5555_5555;
        address_pool[3] = 48'hAAAA_AAAA_AAAA;
        address_pool[4] = 48'h0000_0000_0001;
        address_pool[5] = 48'h7FFF_FFFF_FFFF;
        for (int i = 6; i < POOL_SIZE; i++) begin
            do begin
                address_pool[i] = ADDR_W'({$urandom(), $urandom()});
                unique_addr = 1'b1;
                for (int j = 0; j < i; j++)
                    if (address_pool[j] == address_pool[i])
                        unique_addr = 1'b0;
            end while (!unique_addr);
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(20, 54);
        test_extremes();
        test_ring_wrap();
        test_random_sightings(400, 3);
        pause_until_drained();
        test_table_full();

        set_idling(54, 20);
        test_random_sightings(400, 10);
        pause_until_drained();

        set_idling(0, 0);
        test_random_sightings(400, 10);

        in_valid <= 1'b0;
        while (table_outcomes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (table_outcomes.size() != 0) begin
            mismatch_count += table_outcomes.size();
            $display("%0d results never arrived", table_outcomes.size());
        end

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
